@@ rtl/rpn_stack_calculator_assert.svh @@
// Assertion macros for the RPN stack calculator checker.
// Needs clk and rst_n in scope at the point of use.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPN_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPN_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rpn_pkg.sv @@
// Shared types, codes and constants of the RPN stack calculator.
// No dependencies; used by scoped names everywhere but rpn_ram and the header.
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int ACTION_W = 4;
  localparam int VALUE_W  = 32;
  localparam int DEPTH_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 4'd0,
    ACT_POP   = 4'd1,
    ACT_ADD   = 4'd2,
    ACT_SUB   = 4'd3,
    ACT_MUL   = 4'd4,
    ACT_DIV   = 4'd5,
    ACT_SWAP  = 4'd6,
    ACT_DUP   = 4'd7,
    ACT_CLEAR = 4'd8
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REFILL,
    S_EXEC,
    S_SWAP,
    S_ALU,
    S_DONE
  } state_t;

endpackage

@@ rtl/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/rpn_alu.sv @@
// Iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
// One adder serves every operation. Depends on rpn_pkg.
module rpn_alu #(
  parameter int DATA_WIDTH = rpn_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpn_pkg::alu_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] lhs,
  input  logic [DATA_WIDTH-1:0] rhs,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  rpn_pkg::alu_op_t      op_r, op_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic                  neg_r, neg_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;

  logic [DATA_WIDTH-1:0] add_x, add_y;
  logic                  add_cin;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH-1:0] rem_shift;
  logic [DATA_WIDTH-1:0] lhs_mag, rhs_mag;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign rem_shift = {acc_r[DATA_WIDTH-2:0], a_r[DATA_WIDTH-1]};
  assign lhs_mag   = lhs[DATA_WIDTH-1] ? DATA_WIDTH'(~lhs + DATA_WIDTH'(1)) : lhs;
  assign rhs_mag   = rhs[DATA_WIDTH-1] ? DATA_WIDTH'(~rhs + DATA_WIDTH'(1)) : rhs;

  always_comb begin
    add_x   = a_r;
    add_y   = b_r;
    add_cin = 1'b0;
    case (op_r)
      rpn_pkg::ALU_ADD: begin
        add_x = a_r;
        add_y = b_r;
      end
      rpn_pkg::ALU_SUB: begin
        add_y   = ~b_r;
        add_cin = 1'b1;
      end
      rpn_pkg::ALU_MUL: begin
        add_x = acc_r;
        add_y = b_r[0] ? a_r : '0;
      end
      rpn_pkg::ALU_DIV: begin
        if (cnt_r != '0) begin
          add_x   = rem_shift;
          add_y   = ~b_r;
          add_cin = 1'b1;
        end else begin
          // Final pass applies the quotient sign.
          add_x   = neg_r ? ~a_r : a_r;
          add_y   = '0;
          add_cin = neg_r;
        end
      end
      default: begin
        add_x = a_r;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + (DATA_WIDTH + 1)'(add_cin);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = CNT_W'(DATA_WIDTH);
      acc_nxt  = '0;
      neg_nxt  = lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
      if (ctl.op == rpn_pkg::ALU_DIV) begin
        a_nxt = lhs_mag;
        b_nxt = rhs_mag;
      end else begin
        a_nxt = lhs;
        b_nxt = rhs;
      end
    end else if (busy_r) begin
      case (op_r)
        rpn_pkg::ALU_ADD, rpn_pkg::ALU_SUB: begin
          res_nxt  = sum[DATA_WIDTH-1:0];
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        rpn_pkg::ALU_MUL: begin
          acc_nxt = sum[DATA_WIDTH-1:0];
          a_nxt   = {a_r[DATA_WIDTH-2:0], 1'b0};
          b_nxt   = {1'b0, b_r[DATA_WIDTH-1:1]};
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            res_nxt  = sum[DATA_WIDTH-1:0];
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        rpn_pkg::ALU_DIV: begin
          if (cnt_r != '0) begin
            acc_nxt = sum[DATA_WIDTH] ? sum[DATA_WIDTH-1:0] : rem_shift;
            a_nxt   = {a_r[DATA_WIDTH-2:0], sum[DATA_WIDTH]};
            cnt_nxt = cnt_r - CNT_W'(1);
          end else begin
            res_nxt  = sum[DATA_WIDTH-1:0];
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

@@ rtl/rpn_stack_calculator.sv @@
// Top level of the integer RPN stack calculator: sequencer, stack RAM, arithmetic unit.
// Depends on rpn_pkg, rpn_ram and rpn_alu.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_ready | in_action, in_push_value
//  out_    | output    | out_valid/out_ready | out_result_value, out_depth, out_status
//
// Push, dup, clear, unused codes, pop of the last entry and requests refused at once
// go from idle straight to done; pop with entries left passes refill, divide by zero
// exec, swap exec and swap, add and sub exec and ALU (stack RAM read plus ALU pass).
// Multiply and divide stay in the ALU state, the shared adder doing one bit per cycle.
// The top of stack sits in a register, the rest in the RAM.
// Reset empties the stack at once; the RAM contents are never cleared.
// A new request is taken while a result still waits on out_ready.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = rpn_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rpn_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [rpn_pkg::VALUE_W-1:0]  in_push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rpn_pkg::VALUE_W-1:0]  out_result_value,
  output logic [rpn_pkg::DEPTH_W-1:0]         out_depth,
  output logic [rpn_pkg::STATUS_W-1:0]        out_status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  rpn_pkg::state_t  state_r, state_nxt;
  rpn_pkg::action_t act_r, act_nxt;
  rpn_pkg::action_t in_act;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] top_r, top_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  rpn_pkg::status_t      sta_r, sta_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic signed [rpn_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [rpn_pkg::DEPTH_W-1:0]     out_depth_r, out_depth_nxt;
  rpn_pkg::status_t                out_status_r, out_status_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  rpn_pkg::alu_ctl_t     alu_ctl;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;
  rpn_pkg::alu_op_t      alu_op;

  logic [CW-1:0]         cnt_m1, cnt_m2;
  logic                  empty, full, two_plus;
  logic [DATA_WIDTH-1:0] top_or_zero, push_val;

  assign in_act      = rpn_pkg::action_t'(in_action);
  assign cnt_m1      = count_r - CW'(1);
  assign cnt_m2      = count_r - CW'(2);
  assign empty       = (count_r == '0);
  assign full        = (count_r == CW'(STACK_DEPTH));
  assign two_plus    = (count_r >= CW'(2));
  assign top_or_zero = empty ? '0 : top_r;
  assign push_val    = DATA_WIDTH'($unsigned(in_push_value));
  assign in_ready    = (state_r == rpn_pkg::S_IDLE);

  always_comb begin
    case (act_r)
      rpn_pkg::ACT_SUB: alu_op = rpn_pkg::ALU_SUB;
      rpn_pkg::ACT_MUL: alu_op = rpn_pkg::ALU_MUL;
      rpn_pkg::ACT_DIV: alu_op = rpn_pkg::ALU_DIV;
      default:          alu_op = rpn_pkg::ALU_ADD;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    res_nxt        = res_r;
    sta_nxt        = sta_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = top_r;
    ram_re         = 1'b0;
    ram_raddr      = cnt_m2[AW-1:0];
    alu_ctl.start  = 1'b0;
    alu_ctl.op     = alu_op;

    case (state_r)
      rpn_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_act;
          sta_nxt   = rpn_pkg::ST_OK;
          res_nxt   = top_or_zero;
          state_nxt = rpn_pkg::S_DONE;
          case (in_act)
            rpn_pkg::ACT_PUSH: begin
              if (full) begin
                sta_nxt = rpn_pkg::ST_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = push_val;
                top_nxt   = push_val;
                count_nxt = count_r + CW'(1);
                res_nxt   = push_val;
              end
            end
            rpn_pkg::ACT_POP: begin
              if (empty) begin
                sta_nxt = rpn_pkg::ST_UNDER;
              end else begin
                count_nxt = cnt_m1;
                // The entry below the old top becomes the new top.
                if (two_plus) begin
                  ram_re    = 1'b1;
                  state_nxt = rpn_pkg::S_REFILL;
                end
              end
            end
            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV,
            rpn_pkg::ACT_SWAP: begin
              if (!two_plus) begin
                sta_nxt = rpn_pkg::ST_UNDER;
              end else begin
                ram_re    = 1'b1;
                state_nxt = rpn_pkg::S_EXEC;
              end
            end
            rpn_pkg::ACT_DUP: begin
              if (empty) begin
                sta_nxt = rpn_pkg::ST_UNDER;
              end else if (full) begin
                sta_nxt = rpn_pkg::ST_OVER;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            rpn_pkg::ACT_CLEAR: begin
              count_nxt = '0;
              res_nxt   = '0;
            end
            default: begin
              sta_nxt = rpn_pkg::ST_OK;
            end
          endcase
        end
      end

      rpn_pkg::S_REFILL: begin
        top_nxt   = ram_rdata;
        state_nxt = rpn_pkg::S_DONE;
      end

      rpn_pkg::S_EXEC: begin
        if (act_r == rpn_pkg::ACT_SWAP) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[AW-1:0];
          ram_wdata = top_r;
          state_nxt = rpn_pkg::S_SWAP;
        end else if (act_r == rpn_pkg::ACT_DIV && top_r == '0) begin
          sta_nxt   = rpn_pkg::ST_DIV0;
          state_nxt = rpn_pkg::S_DONE;
        end else begin
          alu_ctl.start = 1'b1;
          state_nxt     = rpn_pkg::S_ALU;
        end
      end

      rpn_pkg::S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m1[AW-1:0];
        ram_wdata = ram_rdata;
        top_nxt   = ram_rdata;
        res_nxt   = ram_rdata;
        state_nxt = rpn_pkg::S_DONE;
      end

      rpn_pkg::S_ALU: begin
        if (alu_done) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[AW-1:0];
          ram_wdata = alu_result;
          top_nxt   = alu_result;
          res_nxt   = alu_result;
          count_nxt = cnt_m1;
          state_nxt = rpn_pkg::S_DONE;
        end
      end

      rpn_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rpn_pkg::VALUE_W'(res_r);
          out_depth_nxt  = rpn_pkg::DEPTH_W'(count_r);
          out_status_nxt = sta_r;
          state_nxt      = rpn_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rpn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpn_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    top_r        <= top_nxt;
    res_r        <= res_nxt;
    sta_r        <= sta_nxt;
    out_value_r  <= out_value_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  rpn_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Right operand is the cached top, left operand the entry read from the RAM.
  rpn_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .lhs    (ram_rdata),
    .rhs    (top_r),
    .done   (alu_done),
    .result (alu_result)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_depth        = out_depth_r;
  assign out_status       = out_status_r;

endmodule

@@ rtl/rpn_checker.sv @@
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and the macros in rpn_stack_calculator_assert.svh.
`include "rpn_stack_calculator_assert.svh"

module rpn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [rpn_pkg::ACTION_W-1:0]       in_action,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rpn_pkg::VALUE_W-1:0] out_result_value,
  input logic [rpn_pkg::DEPTH_W-1:0]        out_depth,
  input logic [rpn_pkg::STATUS_W-1:0]       out_status
);

  // At most two requests are in flight: one in the result register, one at work.
  logic [rpn_pkg::ACTION_W-1:0] act_q_r [2];
  logic                         wp_r, rp_r;
  logic [rpn_pkg::ACTION_W-1:0] head;
  logic                         in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign head    = act_q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (in_acc) begin
        wp_r <= ~wp_r;
      end
      if (out_acc) begin
        rp_r <= ~rp_r;
      end
    end
    if (in_acc) begin
      act_q_r[wp_r] <= in_action;
    end
  end

  `RPN_CHK_NOW(a_div0_only_on_div,
    out_valid && out_status == rpn_pkg::ST_DIV0,
    head == rpn_pkg::ACT_DIV,
    "divide-by-zero status on a request that is not a divide")

  `RPN_CHK_NOW(a_over_only_on_grow,
    out_valid && out_status == rpn_pkg::ST_OVER,
    head == rpn_pkg::ACT_PUSH || head == rpn_pkg::ACT_DUP,
    "overflow status on a request that cannot grow the stack")

  `RPN_CHK_NOW(a_clear_empties,
    out_valid && head == rpn_pkg::ACT_CLEAR,
    out_depth == '0 && out_result_value == '0 && out_status == rpn_pkg::ST_OK,
    "clear did not report an empty stack")

  `RPN_CHK_NEXT(a_out_hold,
    out_valid && !out_ready,
    out_valid && $stable(out_result_value) && $stable(out_depth) && $stable(out_status),
    "stalled result changed before it was taken")

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_depth        (out_depth),
  .out_status       (out_status)
);

@@ bench/tb_rpn_stack_calculator.sv @@
// Self-checking testbench for rpn_stack_calculator: directed corner cases, then random bursts.
// A scoreboard class keeps its own copy of the stack and predicts every response.
// Depends on rpn_pkg and the RTL of the calculator; nothing else.
module tb_rpn_stack_calculator;

  localparam int          STK_DEPTH    = rpn_pkg::STACK_DEPTH_DEF;
  localparam int          TOTAL_ITEMS  = 1950;
  localparam int          HOLD_AT      = 1100;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STEADY_FROM  = 400;
  localparam int          STEADY_TO    = 700;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [3:0]  ACT_UNUSED_LO = 4'(rpn_pkg::ACT_CLEAR) + 4'd1;
  localparam logic [3:0]  ACT_UNUSED_HI = 4'hF;
  localparam logic [31:0] FILLER       = 32'hA5A5_5A5A;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} burst_mode_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [4:0]         depth;
    rpn_pkg::status_t   status;
  } stack_result_t;

  class rpn_scoreboard;
    logic signed [31:0] entries [STK_DEPTH];
    int unsigned        fill;
    stack_result_t      awaiting [$];
    int unsigned        errors;
    int unsigned        noted;
    int unsigned        checked;
    int unsigned        status_seen [4];

    function new();
      fill = 0;
      errors = 0;
      noted = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Applies one request to the shadow stack and queues the response it must give.
    function void note_request(logic [3:0] act, logic signed [31:0] val);
      stack_result_t      res;
      logic signed [31:0] lhs, rhs, v;
      logic [31:0]        mag_l, mag_r, quo;
      bit                 popped;
      popped = 0;
      v = '0;
      res.status = rpn_pkg::ST_OK;
      case (act)
        rpn_pkg::ACT_PUSH: begin
          if (fill >= STK_DEPTH) res.status = rpn_pkg::ST_OVER;
          else begin
            entries[fill] = val;
            fill++;
          end
        end
        rpn_pkg::ACT_POP: begin
          if (fill == 0) res.status = rpn_pkg::ST_UNDER;
          else begin
            fill--;
            res.value = entries[fill];
            popped = 1;
          end
        end
        rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
          if (fill < 2) res.status = rpn_pkg::ST_UNDER;
          else begin
            rhs = entries[fill-1];
            lhs = entries[fill-2];
            case (act)
              rpn_pkg::ACT_ADD: v = lhs + rhs;
              rpn_pkg::ACT_SUB: v = lhs - rhs;
              rpn_pkg::ACT_MUL: v = lhs * rhs;
              default: begin
                if (rhs == 0) res.status = rpn_pkg::ST_DIV0;
                else begin
                  // Divide magnitudes, then fix the sign: truncates toward zero and
                  // lets the most negative value over minus one wrap to itself.
                  mag_l = lhs[31] ? (~lhs + 32'd1) : lhs;
                  mag_r = rhs[31] ? (~rhs + 32'd1) : rhs;
                  quo = mag_l / mag_r;
                  v = (lhs[31] ^ rhs[31]) ? (~quo + 32'd1) : quo;
                end
              end
            endcase
            if (res.status == rpn_pkg::ST_OK) begin
              fill--;
              entries[fill-1] = v;
            end
          end
        end
        rpn_pkg::ACT_SWAP: begin
          if (fill < 2) res.status = rpn_pkg::ST_UNDER;
          else begin
            v = entries[fill-1];
            entries[fill-1] = entries[fill-2];
            entries[fill-2] = v;
          end
        end
        rpn_pkg::ACT_DUP: begin
          if (fill == 0) res.status = rpn_pkg::ST_UNDER;
          else if (fill >= STK_DEPTH) res.status = rpn_pkg::ST_OVER;
          else begin
            entries[fill] = entries[fill-1];
            fill++;
          end
        end
        rpn_pkg::ACT_CLEAR: fill = 0;
        default: ;
      endcase
      if (!popped) res.value = (fill == 0) ? '0 : entries[fill-1];
      res.depth = 5'(fill);
      status_seen[res.status]++;
      noted++;
      awaiting.push_back(res);
    endfunction

    task check_result(logic signed [31:0] v, logic [4:0] d, logic [1:0] s);
      stack_result_t want;
      if (awaiting.size() == 0) begin
        report($sformatf("response with none expected: value %0d depth %0d status %0d",
                         v, d, s));
        return;
      end
      want = awaiting.pop_front();
      checked++;
      if (v !== want.value)
        report($sformatf("response %0d: value %0d, expected %0d", checked, v, want.value));
      if (d !== want.depth)
        report($sformatf("response %0d: depth %0d, expected %0d", checked, d, want.depth));
      if (s !== want.status)
        report($sformatf("response %0d: status %0d, expected %0d", checked, s, want.status));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         in_action;
  logic signed [31:0] in_push_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_result_value;
  logic [4:0]         out_depth;
  logic [1:0]         out_status;

  rpn_scoreboard sb;
  int            sent;
  int            cycles;
  int            hold_left;
  bit            hold_done;
  logic          steady;

  // During this window neither side idles.
  assign steady = (sent >= STEADY_FROM) && (sent < STEADY_TO);

  rpn_stack_calculator #(
    .STACK_DEPTH(STK_DEPTH),
    .DATA_WIDTH (rpn_pkg::DATA_WIDTH_DEF)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_value(out_result_value),
    .out_depth       (out_depth),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, sb.pending());
      $display("tb_rpn_stack_calculator: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_action, in_push_value);
      if (out_valid && out_ready) sb.check_result(out_result_value, out_depth, out_status);
    end
  end

  // Result side: random stalls, plus one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && sent >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 18);
    end
  end

  task automatic send_request(input logic [3:0] act, input logic signed [31:0] val);
    if (!steady && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_push_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 55) return 32'(int'($urandom_range(0, 40)) - 20);
    if (r < 63) return '0;
    if (r < 73) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return '1;
        default: return 32'sd1;
      endcase
    end
    return 32'($signed(16'($urandom)));
  endfunction

  function automatic logic [3:0] pick_action(burst_mode_t mode);
    int unsigned r;
    logic [3:0]  other;
    r = $urandom_range(0, 99);
    // Anything from pop through swap.
    other = 4'(rpn_pkg::ACT_POP) + 4'($urandom_range(0, 5));
    if (r < 2) return rpn_pkg::ACT_CLEAR;
    if (r < 4) return ACT_UNUSED_LO + 4'($urandom_range(0, ACT_UNUSED_HI - ACT_UNUSED_LO));
    case (mode)
      MODE_FILL: begin
        if (r < 70) return rpn_pkg::ACT_PUSH;
        if (r < 80) return rpn_pkg::ACT_DUP;
      end
      MODE_MIXED: begin
        if (r < 40) return rpn_pkg::ACT_PUSH;
        if (r < 48) return rpn_pkg::ACT_DUP;
      end
      default: begin
        if (r < 25) return rpn_pkg::ACT_PUSH;
      end
    endcase
    return other;
  endfunction

  logic [3:0]         dir_act [25];
  logic signed [31:0] dir_val [25];

  initial begin
    burst_mode_t mode;
    int          burst;
    logic [3:0]  act;

    sb = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = rpn_pkg::ACT_PUSH;
    in_push_value = '0;
    out_ready     = 1'b0;
    sent          = 0;
    cycles        = 0;
    hold_left     = 0;
    hold_done     = 0;

    // Empty-stack errors, wrap on add, most negative over minus one, divide by zero,
    // swap with a single entry, unused codes, and non-push values that must be ignored.
    dir_act = '{rpn_pkg::ACT_POP,  rpn_pkg::ACT_ADD,  rpn_pkg::ACT_DUP,
                rpn_pkg::ACT_SWAP, rpn_pkg::ACT_CLEAR,
                rpn_pkg::ACT_PUSH, rpn_pkg::ACT_SWAP, rpn_pkg::ACT_PUSH,
                rpn_pkg::ACT_ADD,  rpn_pkg::ACT_DUP,
                rpn_pkg::ACT_PUSH, rpn_pkg::ACT_DIV,  rpn_pkg::ACT_PUSH,
                rpn_pkg::ACT_DIV,  rpn_pkg::ACT_POP,
                rpn_pkg::ACT_MUL,  rpn_pkg::ACT_PUSH, rpn_pkg::ACT_PUSH,
                rpn_pkg::ACT_PUSH, rpn_pkg::ACT_DIV,
                rpn_pkg::ACT_SUB,  ACT_UNUSED_LO,     ACT_UNUSED_HI,
                rpn_pkg::ACT_SWAP, rpn_pkg::ACT_CLEAR};
    dir_val = '{FILLER, FILLER, FILLER, FILLER, FILLER,
                32'h7FFF_FFFF, FILLER, 32'sd1, FILLER, FILLER,
                -32'sd1, FILLER, 32'sd0, FILLER, FILLER,
                FILLER, 32'h8000_0000, -32'sd7, 32'sd2, FILLER,
                FILLER, FILLER, FILLER, FILLER, FILLER};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_act[i]) send_request(dir_act[i], dir_val[i]);

    while (sent < TOTAL_ITEMS) begin
      mode  = burst_mode_t'($urandom_range(0, 2));
      burst = $urandom_range(8, 40);
      repeat (burst) begin
        act = pick_action(mode);
        send_request(act, pick_value());
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d requests, noted %0d, checked %0d responses",
             sent, sb.noted, sb.checked);
    $display("status mix: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
             sb.status_seen[rpn_pkg::ST_OK], sb.status_seen[rpn_pkg::ST_UNDER],
             sb.status_seen[rpn_pkg::ST_OVER], sb.status_seen[rpn_pkg::ST_DIV0]);
    if (sb.errors == 0) begin
      $display("tb_rpn_stack_calculator: done, clean");
    end else begin
      $display("tb_rpn_stack_calculator: done, errors");
    end
    $finish;
  end

endmodule
